// ===== rtl/ucb_pkg.sv =====
package ucb_pkg;

    localparam int NUM_ARMS     = 11;
    localparam int NUM_CHANNELS = 4;
    localparam int ARM_W        = 4;
    localparam int PROB_W       = 16;
    localparam int LIMIT_W      = 3;
    localparam int MASK_W       = 44;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 44;
    localparam int QUART_W      = 36;
    localparam int CNT_W        = 32;
    localparam int REWARD_W     = 3;

    // Shared divider: dividend width covers (quarters << 14)
    localparam int DIV_W        = 50;
    localparam int DIV_CNT_W    = 6;
    // Square root operand width and step count (two bits per step)
    localparam int SQ_W         = 38;
    localparam int SQ_STEPS     = SQ_W / 2;
    localparam int SQ_CNT_W     = 5;
    localparam int LOG_STEPS    = 16;
    localparam int LN_W         = 22;

    localparam logic [15:0] LN2_Q16 = 16'd45426;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PROB0  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PROB1  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PROB2  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PROB3  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_MASKS  = 3'd5;

    localparam logic [PROB_W-1:0]  PROB0_RST = 16'd6554;
    localparam logic [PROB_W-1:0]  PROB1_RST = 16'd19661;
    localparam logic [PROB_W-1:0]  PROB2_RST = 16'd32768;
    localparam logic [PROB_W-1:0]  PROB3_RST = 16'd45875;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 3'd2;
    localparam logic [MASK_W-1:0]  MASKS_RST = 44'd17513998546515;

endpackage

// ===== rtl/ucb_subset_bandit_step_top.sv =====
// UCB1 subset bandit, one round per transaction.
// For the first eleven rounds the input transaction goes straight to the update step;
//   afterwards the block runs log2 by 16 squarings, then per arm two 50-step divisions,
//   a square root and a compare on one shared datapath, before the update step.
// One round at a time; s_tready is high only while idle, and a result that is not taken
//   holds the block in its last step.
// Reset: async active low; config registers take their defaults, per-arm
//   rewards reset to 4 quarters and pull counts to 1, totals to zero.
module ucb_subset_bandit_step_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [15:0]                        s_tdata,  // [15:0] random_sample
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [39:0]                        m_tdata,  // [3:0] chosen_arm,
                                                         // [6:4] round_reward,
                                                         // [38:7] total_reward
    input  logic                               cfg_we,
    input  logic [ucb_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [ucb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOG_INIT, ST_LOG, ST_LN, ST_DIVX_INIT, ST_DIVX,
        ST_DIVL_INIT, ST_DIVL, ST_SQRT, ST_CMP, ST_UPDATE
    } state_t;

    state_t state_reg;

    logic [ucb_pkg::PROB_W-1:0]   prob_reg [4];
    logic [ucb_pkg::LIMIT_W-1:0]  limit_reg;
    logic [ucb_pkg::MASK_W-1:0]   masks_reg;

    logic [ucb_pkg::QUART_W-1:0]  quart_reg [ucb_pkg::NUM_ARMS];
    logic [ucb_pkg::CNT_W-1:0]    pull_reg  [ucb_pkg::NUM_ARMS];
    logic [ucb_pkg::CNT_W-1:0]    rounds_reg;
    logic [ucb_pkg::CNT_W-1:0]    sum_reg;

    logic [15:0]                  sample_reg;
    logic [ucb_pkg::ARM_W-1:0]    arm_reg;
    logic [ucb_pkg::ARM_W-1:0]    best_arm_reg;
    logic [31:0]                  best_reg;

    logic [30:0]                  z_reg;
    logic [5:0]                   exp_reg;
    logic [15:0]                  frac_reg;
    logic [4:0]                   log_cnt_reg;
    logic [ucb_pkg::LN_W-1:0]     ln_reg;

    logic [ucb_pkg::DIV_W-1:0]    dq_reg;
    logic [31:0]                  rem_reg;
    logic [31:0]                  t_reg;
    logic [ucb_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [ucb_pkg::DIV_W-1:0]    qx_reg;

    logic [ucb_pkg::SQ_W-1:0]     sv_reg;
    logic [ucb_pkg::SQ_W-1:0]     sres_reg;
    logic [ucb_pkg::SQ_W-1:0]     sbit_reg;
    logic [ucb_pkg::SQ_CNT_W-1:0] sq_cnt_reg;

    logic                         out_valid_reg;
    logic [39:0]                  out_data_reg;

    // Normalize n = NUM_ARMS + rounds_done into Q1.30
    logic [32:0] n_val;
    logic [5:0]  n_msb;
    logic [63:0] n_wide;
    logic [30:0] z_init;
    always_comb
    begin
        n_val = {1'b0, rounds_reg} + 33'(ucb_pkg::NUM_ARMS);
        n_msb = '0;
        for (int i = 0; i < 33; i++)
        begin
            if (n_val[i])
                n_msb = 6'(i);
        end
        n_wide = (n_msb >= 6'd30) ? (64'(n_val) >> (n_msb - 6'd30))
                                  : (64'(n_val) << (6'd30 - n_msb));
        z_init = n_wide[30:0];
    end

    // One squaring of the log2 iteration
    logic [61:0] z_sq;
    logic [31:0] z_sq_hi;
    assign z_sq    = z_reg * z_reg;
    assign z_sq_hi = z_sq[61:30];

    // ln = log2 * ln(2)
    logic [37:0] ln_prod;
    assign ln_prod = {exp_reg, frac_reg} * ucb_pkg::LN2_Q16;

    // Restoring divider step
    logic [32:0] div_trial;
    logic        div_ge;
    assign div_trial = {rem_reg, dq_reg[ucb_pkg::DIV_W-1]};
    assign div_ge    = div_trial >= {1'b0, t_reg};

    // Square root step
    logic [ucb_pkg::SQ_W-1:0] sq_sum;
    assign sq_sum = sres_reg + sbit_reg;

    // Index sum with saturation
    logic [ucb_pkg::DIV_W:0] idx_sum;
    logic [31:0]             idx_sat;
    assign idx_sum = {1'b0, qx_reg} + (ucb_pkg::DIV_W + 1)'(sres_reg);
    assign idx_sat = (idx_sum > (ucb_pkg::DIV_W + 1)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                      : idx_sum[31:0];

    // Reward of the chosen arm
    logic [ucb_pkg::NUM_CHANNELS-1:0] arm_mask;
    logic [2:0]                       masked_cnt;
    logic [2:0]                       vacant_cnt;
    logic [2:0]                       vacant;
    always_comb
    begin
        arm_mask   = masks_reg[arm_reg * ucb_pkg::NUM_CHANNELS +: ucb_pkg::NUM_CHANNELS];
        masked_cnt = '0;
        vacant_cnt = '0;
        for (int j = 0; j < ucb_pkg::NUM_CHANNELS; j++)
        begin
            if (arm_mask[j])
            begin
                masked_cnt = masked_cnt + 3'd1;
                if (sample_reg < prob_reg[ucb_pkg::NUM_CHANNELS - 1 - j])
                    vacant_cnt = vacant_cnt + 3'd1;
            end
        end
        vacant = ((masked_cnt - vacant_cnt) > limit_reg) ? 3'd0 : vacant_cnt;
    end

    logic [ucb_pkg::QUART_W:0] quart_inc;
    logic [32:0]               sum_inc;
    logic [31:0]               sum_new;
    assign quart_inc = {1'b0, quart_reg[arm_reg]} + (ucb_pkg::QUART_W + 1)'(vacant);
    assign sum_inc   = {1'b0, sum_reg} + 33'(vacant);
    assign sum_new   = sum_inc[32] ? 32'hFFFF_FFFF : sum_inc[31:0];

    logic [31:0] t_sel;
    assign t_sel = (pull_reg[arm_reg] == '0) ? 32'd1 : pull_reg[arm_reg];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prob_reg[0] <= ucb_pkg::PROB0_RST;
            prob_reg[1] <= ucb_pkg::PROB1_RST;
            prob_reg[2] <= ucb_pkg::PROB2_RST;
            prob_reg[3] <= ucb_pkg::PROB3_RST;
            limit_reg   <= ucb_pkg::LIMIT_RST;
            masks_reg   <= ucb_pkg::MASKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                ucb_pkg::REG_PROB0: prob_reg[0] <= cfg_data[15:0];
                ucb_pkg::REG_PROB1: prob_reg[1] <= cfg_data[15:0];
                ucb_pkg::REG_PROB2: prob_reg[2] <= cfg_data[15:0];
                ucb_pkg::REG_PROB3: prob_reg[3] <= cfg_data[15:0];
                ucb_pkg::REG_LIMIT: limit_reg   <= cfg_data[2:0];
                ucb_pkg::REG_MASKS: masks_reg   <= cfg_data[ucb_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequence one round through the shared datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int a = 0; a < ucb_pkg::NUM_ARMS; a++)
            begin
                quart_reg[a] <= 36'd4;
                pull_reg[a]  <= 32'd1;
            end
            rounds_reg    <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            arm_reg       <= '0;
            best_arm_reg  <= '0;
            log_cnt_reg   <= '0;
            div_cnt_reg   <= '0;
            sq_cnt_reg    <= '0;
        end
        else
        begin
            // drop the result once taken, unless the update step reloads it
            if (out_valid_reg && m_tready && state_reg != ST_UPDATE)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        sample_reg <= s_tdata;
                        if (rounds_reg < 32'(ucb_pkg::NUM_ARMS))
                        begin
                            arm_reg   <= rounds_reg[ucb_pkg::ARM_W-1:0];
                            state_reg <= ST_UPDATE;
                        end
                        else
                            state_reg <= ST_LOG_INIT;
                    end
                end
                ST_LOG_INIT:
                begin
                    z_reg       <= z_init;
                    exp_reg     <= n_msb;
                    frac_reg    <= '0;
                    log_cnt_reg <= 5'(ucb_pkg::LOG_STEPS);
                    state_reg   <= ST_LOG;
                end
                ST_LOG:
                begin
                    // square, emit a fraction bit, renormalize
                    if (z_sq_hi[31])
                    begin
                        z_reg    <= z_sq_hi[31:1];
                        frac_reg <= {frac_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        z_reg    <= z_sq_hi[30:0];
                        frac_reg <= {frac_reg[14:0], 1'b0};
                    end
                    log_cnt_reg <= log_cnt_reg - 5'd1;
                    if (log_cnt_reg == 5'd1)
                        state_reg <= ST_LN;
                end
                ST_LN:
                begin
                    ln_reg    <= ln_prod[37:16];
                    arm_reg   <= '0;
                    state_reg <= ST_DIVX_INIT;
                end
                ST_DIVX_INIT:
                begin
                    dq_reg      <= {quart_reg[arm_reg], 14'd0};
                    rem_reg     <= '0;
                    t_reg       <= t_sel;
                    div_cnt_reg <= 6'(ucb_pkg::DIV_W);
                    state_reg   <= ST_DIVX;
                end
                ST_DIVX, ST_DIVL:
                begin
                    rem_reg     <= div_ge ? 32'(div_trial - {1'b0, t_reg}) : div_trial[31:0];
                    dq_reg      <= {dq_reg[ucb_pkg::DIV_W-2:0], div_ge};
                    div_cnt_reg <= div_cnt_reg - 6'd1;
                    if (div_cnt_reg == 6'd1)
                        state_reg <= (state_reg == ST_DIVX) ? ST_DIVL_INIT : ST_SQRT;
                end
                ST_DIVL_INIT:
                begin
                    qx_reg      <= dq_reg;
                    dq_reg      <= ucb_pkg::DIV_W'({ln_reg, 16'd0});
                    rem_reg     <= '0;
                    div_cnt_reg <= 6'(ucb_pkg::DIV_W);
                    sv_reg      <= '0;
                    sres_reg    <= '0;
                    sq_cnt_reg  <= '0;
                    state_reg   <= ST_DIVL;
                end
                ST_SQRT:
                begin
                    // load the quotient on the first step, then iterate
                    if (sq_cnt_reg == '0)
                    begin
                        sv_reg     <= dq_reg[ucb_pkg::SQ_W-1:0];
                        sres_reg   <= '0;
                        sbit_reg   <= ucb_pkg::SQ_W'(1) << (ucb_pkg::SQ_W - 2);
                        sq_cnt_reg <= 5'(ucb_pkg::SQ_STEPS);
                    end
                    else
                    begin
                        if (sv_reg >= sq_sum)
                        begin
                            sv_reg   <= sv_reg - sq_sum;
                            sres_reg <= (sres_reg >> 1) + sbit_reg;
                        end
                        else
                            sres_reg <= sres_reg >> 1;
                        sbit_reg   <= sbit_reg >> 2;
                        sq_cnt_reg <= sq_cnt_reg - 5'd1;
                        if (sq_cnt_reg == 5'd1)
                            state_reg <= ST_CMP;
                    end
                end
                ST_CMP:
                begin
                    if (arm_reg == '0 || idx_sat > best_reg)
                    begin
                        best_reg     <= idx_sat;
                        best_arm_reg <= arm_reg;
                    end
                    if (arm_reg == ucb_pkg::ARM_W'(ucb_pkg::NUM_ARMS - 1))
                    begin
                        arm_reg   <= (arm_reg == '0 || idx_sat > best_reg) ? arm_reg
                                                                         : best_arm_reg;
                        state_reg <= ST_UPDATE;
                    end
                    else
                    begin
                        arm_reg   <= arm_reg + 4'd1;
                        state_reg <= ST_DIVX_INIT;
                    end
                end
                ST_UPDATE:
                begin
                    // wait for the output register to free up
                    if (!out_valid_reg || m_tready)
                    begin
                        quart_reg[arm_reg] <= quart_inc[ucb_pkg::QUART_W] ? '1
                                              : quart_inc[ucb_pkg::QUART_W-1:0];
                        if (pull_reg[arm_reg] != 32'hFFFF_FFFF)
                            pull_reg[arm_reg] <= pull_reg[arm_reg] + 32'd1;
                        if (rounds_reg != 32'hFFFF_FFFF)
                            rounds_reg <= rounds_reg + 32'd1;
                        sum_reg       <= sum_new;
                        out_data_reg  <= {1'b0, sum_new, vacant, arm_reg};
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // A result never names an arm past the last one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:0] < ucb_pkg::ARM_W'(ucb_pkg::NUM_ARMS)))
        else $error("chosen arm out of range");

    // A round that is taken leaves the block busy, so no second round is accepted back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accepted a second round back to back");

    // The shared divider never leaves a remainder at or above its divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVX || state_reg == ST_DIVL) |-> (rem_reg < t_reg))
        else $error("divider remainder out of range");

endmodule
